@@ hw/rtl/evhg_pkg.sv @@
package evhg_pkg;

   localparam int SAMPLE_W              = 16;
   localparam int TIME_W                = 48;
   localparam int THRESH_W              = 16;
   localparam int HOLD_W                = 24;
   localparam int MEAN_W                = 16;
   localparam int CSR_DATA_W            = 24;
   localparam int CSR_IDX_W             = 1;
   localparam int MAX_FRAME_SAMPLES_DEF = 256;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = THRESH_W'(500);
   localparam logic [HOLD_W-1:0]   HOLD_RESET      = HOLD_W'(300000);

   localparam logic [CSR_IDX_W-1:0] CSR_VOICE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME_US    = 1'b1;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_DIVIDE,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/evhg_ctrl.sv @@
module evhg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_frame_end,
   output logic                   req_ready,
   input  evhg_pkg::dp_status_type status,
   output evhg_pkg::ctrl_cmd_type  cmd
);
   import evhg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && req_frame_end) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold until the output register can take the verdict
            if (status.out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_DECIDE: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/evhg_dp.sv @@
module evhg_dp #(
   parameter int MAX_FRAME_SAMPLES = evhg_pkg::MAX_FRAME_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  evhg_pkg::ctrl_cmd_type              cmd,
   output evhg_pkg::dp_status_type             status,
   input  logic signed [evhg_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_frame_end,
   input  logic [evhg_pkg::TIME_W-1:0]         req_now_us,
   input  logic [evhg_pkg::THRESH_W-1:0]       voice_threshold,
   input  logic [evhg_pkg::HOLD_W-1:0]         hold_time_us,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_frame_passed,
   output logic                                rsp_voice_now,
   output logic [evhg_pkg::MEAN_W-1:0]         rsp_mean_level
);
   import evhg_pkg::*;

   localparam int CNT_W     = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W     = 15 + CNT_W;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     sum_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [SAMPLE_W-1:0]  abs_level;

   logic [SUM_W-1:0]     quo_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [CNT_W-1:0]     divisor_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       diff;

   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    last_voice_ff;
   logic                 voice_seen_ff;
   logic [TIME_W-1:0]    elapsed;
   logic [MEAN_W-1:0]    mean;
   logic                 voiced;
   logic                 passed;

   logic                 rsp_valid_ff;
   logic                 passed_ff;
   logic                 voiced_ff;
   logic [MEAN_W-1:0]    mean_ff;

   // -32768 maps to 32768 through the unsigned view
   assign abs_level = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (count_ff < CNT_W'(MAX_FRAME_SAMPLES)) begin
         sum_in   = sum_ff + SUM_W'(abs_level);
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         if (req_frame_end) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept && req_frame_end) begin
         quo_ff     <= sum_in;
         rem_ff     <= '0;
         divisor_ff <= count_in;
         div_cnt_ff <= DIV_CNT_W'(SUM_W - 1);
         now_ff     <= req_now_us;
      end else if (cmd.div_step) begin
         if (!diff[CNT_W]) begin
            rem_ff <= diff[CNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[CNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   assign mean    = quo_ff[MEAN_W-1:0];
   assign voiced  = mean > voice_threshold;
   assign elapsed = now_ff - last_voice_ff;
   assign passed  = voiced || (voice_seen_ff && (elapsed <= TIME_W'(hold_time_us)));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_voice_ff <= '0;
         voice_seen_ff <= 1'b0;
      end else if (cmd.emit && voiced) begin
         last_voice_ff <= now_ff;
         voice_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         passed_ff <= passed;
         voiced_ff <= voiced;
         mean_ff   <= mean;
      end
   end

   assign status.div_last = (div_cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_passed = passed_ff;
   assign rsp_voice_now    = voiced_ff;
   assign rsp_mean_level   = mean_ff;

endmodule

@@ hw/rtl/energy_vad_hold_gate.sv @@
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_sample, req_frame_end, req_now_us
// rsp       rsp_valid/rsp_ready    rsp_frame_passed, rsp_voice_now, rsp_mean_level
// csr       csr_we (no wait)       csr_index, csr_wdata
//
// Samples inside a frame are taken while the block collects. The last sample
// of a frame starts the one-bit-per-cycle restoring divider that forms the
// mean, and req_ready stays low until the verdict goes to the output register.
// Reset is synchronous, active high, and clears the frame sums, the voice
// history and the output valid flag. A verdict waits in the output register
// while the next frame is collected; a stalled rsp side holds back only the
// following frame's verdict.
module energy_vad_hold_gate #(
   parameter int MAX_FRAME_SAMPLES = evhg_pkg::MAX_FRAME_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [evhg_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_frame_end,
   input  logic [evhg_pkg::TIME_W-1:0]         req_now_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_frame_passed,
   output logic                                rsp_voice_now,
   output logic [evhg_pkg::MEAN_W-1:0]         rsp_mean_level,
   input  logic                                csr_we,
   input  logic [evhg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [evhg_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import evhg_pkg::*;

   logic [THRESH_W-1:0] voice_threshold_ff;
   logic [HOLD_W-1:0]   hold_time_us_ff;
   ctrl_cmd_type        cmd;
   dp_status_type       status;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_threshold_ff <= THRESHOLD_RESET;
         hold_time_us_ff    <= HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VOICE_THRESHOLD: voice_threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_HOLD_TIME_US:    hold_time_us_ff    <= csr_wdata[HOLD_W-1:0];
            default:             hold_time_us_ff    <= hold_time_us_ff;
         endcase
      end
   end

   evhg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   evhg_dp #(
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .req_frame_end    (req_frame_end),
      .req_now_us       (req_now_us),
      .voice_threshold  (voice_threshold_ff),
      .hold_time_us     (hold_time_us_ff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_frame_passed (rsp_frame_passed),
      .rsp_voice_now    (rsp_voice_now),
      .rsp_mean_level   (rsp_mean_level)
   );

endmodule
